### sv/rc4kc_pkg.sv
// ----------------------------------------------------------------------------
// rc4kc_pkg: shared types and microcode for the RC4 keystream cipher
// Holds the mode codes, the control word layout and the sequencer program.
// ----------------------------------------------------------------------------
package rc4kc_pkg;

    localparam int KEY_BYTES = 16;

    typedef enum logic [1:0]
    {
        MODE_REKEY = 2'd0,
        MODE_PLAIN = 2'd1,
        MODE_ENC   = 2'd2,
        MODE_DEC   = 2'd3
    } mode_t;

    typedef logic [3:0] step_t;

    localparam step_t STEP_IDLE  = 4'd0;
    localparam step_t STEP_G0    = 4'd1;
    localparam step_t STEP_G1    = 4'd2;
    localparam step_t STEP_G2    = 4'd3;
    localparam step_t STEP_G3    = 4'd4;
    localparam step_t STEP_G4    = 4'd5;
    localparam step_t STEP_KINIT = 4'd6;
    localparam step_t STEP_K0    = 4'd7;
    localparam step_t STEP_K1    = 4'd8;
    localparam step_t STEP_K2    = 4'd9;
    localparam step_t STEP_K3    = 4'd10;
    localparam step_t STEP_KEND  = 4'd11;
    localparam step_t STEP_LAST  = STEP_KEND;

    // port A read address source
    typedef enum logic [2:0]
    {
        RA_X       = 3'd0,   // x
        RA_X_INC   = 3'd1,   // x + 1
        RA_Y_SUM   = 3'd2,   // y + A
        RA_KEY_SUM = 3'd3,   // y + A + key byte
        RA_AB      = 3'd4    // a + b
    } ra_sel_t;

    typedef enum logic [1:0]
    {
        WR_NONE = 2'd0,
        WR_X    = 2'd1,      // T[x] <= A
        WR_Y    = 2'd2       // T[y] <= a
    } wr_sel_t;

    typedef enum logic [1:0]
    {
        X_HOLD = 2'd0,
        X_INC  = 2'd1,
        X_CLR  = 2'd2
    } x_op_t;

    typedef enum logic [1:0]
    {
        Y_HOLD = 2'd0,
        Y_ADDR = 2'd1,       // y <= port A address
        Y_CLR  = 2'd2
    } y_op_t;

    typedef enum logic [1:0]
    {
        J_NEXT     = 2'd0,
        J_DISPATCH = 2'd1,   // rekey -> target, data -> next
        J_GOTO     = 2'd2,
        J_LOOP     = 2'd3    // x != 255 -> target, else next
    } jmp_t;

    typedef struct packed
    {
        ra_sel_t ra_sel;
        logic    rd_a;
        logic    rd_b;
        wr_sel_t wr_sel;
        x_op_t   x_op;
        y_op_t   y_op;
        logic    ld_a;
        logic    ld_b;
        logic    clr_tbl;
        logic    key_step;
        logic    accept;
        logic    emit;
        jmp_t    jmp;
        step_t   target;
    } ucode_t;

    localparam ucode_t UC_NOP = '{
        ra_sel:   RA_X,
        rd_a:     1'b0,
        rd_b:     1'b0,
        wr_sel:   WR_NONE,
        x_op:     X_HOLD,
        y_op:     Y_HOLD,
        ld_a:     1'b0,
        ld_b:     1'b0,
        clr_tbl:  1'b0,
        key_step: 1'b0,
        accept:   1'b0,
        emit:     1'b0,
        jmp:      J_NEXT,
        target:   STEP_IDLE
    };

    // Sequencer program
    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t u;
        u = UC_NOP;
        case (step)
            STEP_IDLE:
            begin
                u.accept = 1'b1;
                u.jmp    = J_DISPATCH;
                u.target = STEP_KINIT;
            end
            STEP_G0:
            begin
                u.ra_sel = RA_X_INC;
                u.rd_a   = 1'b1;
                u.x_op   = X_INC;
            end
            STEP_G1:
            begin
                u.ra_sel = RA_Y_SUM;
                u.rd_a   = 1'b1;
                u.y_op   = Y_ADDR;
                u.ld_a   = 1'b1;
            end
            STEP_G2:
            begin
                u.ld_b   = 1'b1;
                u.wr_sel = WR_X;
            end
            STEP_G3:
            begin
                u.wr_sel = WR_Y;
                u.ra_sel = RA_AB;
                u.rd_a   = 1'b1;
                u.rd_b   = 1'b1;
            end
            STEP_G4:
            begin
                u.emit   = 1'b1;
                u.jmp    = J_GOTO;
                u.target = STEP_IDLE;
            end
            STEP_KINIT:
            begin
                u.clr_tbl = 1'b1;
                u.x_op    = X_CLR;
                u.y_op    = Y_CLR;
            end
            STEP_K0:
            begin
                u.ra_sel = RA_X;
                u.rd_a   = 1'b1;
            end
            STEP_K1:
            begin
                u.ra_sel = RA_KEY_SUM;
                u.rd_a   = 1'b1;
                u.y_op   = Y_ADDR;
                u.ld_a   = 1'b1;
            end
            STEP_K2:
            begin
                u.wr_sel = WR_X;
            end
            STEP_K3:
            begin
                u.wr_sel   = WR_Y;
                u.x_op     = X_INC;
                u.key_step = 1'b1;
                u.jmp      = J_LOOP;
                u.target   = STEP_K0;
            end
            STEP_KEND:
            begin
                u.y_op   = Y_CLR;
                u.jmp    = J_GOTO;
                u.target = STEP_IDLE;
            end
            default:
            begin
                u.jmp    = J_GOTO;
                u.target = STEP_IDLE;
            end
        endcase
        return u;
    endfunction

endpackage

### sv/rc4_keystream_cipher_top.sv
// ----------------------------------------------------------------------------
// rc4_keystream_cipher_top: RC4 byte cipher with plain and enhanced modes
// Microcoded sequencer over a 256 x 8 permutation memory and two indices.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis_*): tdata = data byte, tuser = mode, tlast = end of
//   message. Mode rekey runs the key schedule and gives no output transfer;
//   the other modes each give one output transfer on m_axis_* carrying the
//   transformed byte and the copied tlast.
//   Key bytes and key length are written on the cfg_* port while idle.
// Timing:
//   A data byte runs through steps G0 to G4 after its input transfer, and its
//   result is registered for m_axis_* at G4; no new input is taken before the
//   sequencer is back at its idle step. The steps are set by the single write
//   port of the table memory: the two swap writes and the dependent reads of
//   x, y and a+b run as separate steps. A rekey clears the table to the identity
//   (per-entry valid bits), runs steps K0 to K3 for each of 256 swaps, clears y.
// Reset:
//   Table reads as the identity, x = y = 0, key = 0, key length = 16.
// Backpressure:
//   A finished byte waits in the output register; the next item is still
//   accepted and processed, and the sequencer only waits at its output step
//   while the previous result has not been taken.
// ----------------------------------------------------------------------------
module rc4_keystream_cipher_top
#(
    parameter int MAX_KEY_BYTES = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write port
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_addr,
    input  logic [63:0]            cfg_wdata,
    // input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // [7:0] data_in
    input  rc4kc_pkg::mode_t       s_axis_tuser,   // [1:0] mode
    input  logic                   s_axis_tlast,
    // output stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [7:0]             m_axis_tdata,   // [7:0] data_out
    output logic                   m_axis_tlast
);
    import rc4kc_pkg::*;

    localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

    localparam logic [1:0] CFG_KEY_LOW  = 2'd0;
    localparam logic [1:0] CFG_KEY_HIGH = 2'd1;
    localparam logic [1:0] CFG_KEY_LEN  = 2'd2;

    // configuration
    logic [63:0]       key_low_reg;
    logic [63:0]       key_high_reg;
    logic [4:0]        key_len_reg;

    // sequencer
    step_t             pc_reg;
    step_t             pc_next;
    ucode_t            uc;
    logic              step_en;

    // datapath
    logic [7:0]        x_reg;
    logic [7:0]        y_reg;
    logic [7:0]        a_reg;
    logic [7:0]        b_reg;
    logic [KIDX_W-1:0] kidx_reg;
    logic [4:0]        key_len_eff;
    logic [7:0]        key_sel;
    mode_t             mode_reg;
    logic [7:0]        din_reg;
    logic              last_reg;

    // table memory
    logic [7:0]        mem [256];
    logic [255:0]      vld_reg;
    logic [7:0]        ra_addr;
    logic [7:0]        rb_addr;
    logic              mem_we;
    logic [7:0]        mem_wa;
    logic [7:0]        mem_wd;
    logic [7:0]        rda_data_reg;
    logic              rda_hit_reg;
    logic [7:0]        rda_addr_reg;
    logic [7:0]        rdb_data_reg;
    logic              rdb_hit_reg;
    logic [7:0]        rdb_addr_reg;
    logic [7:0]        rda_val;
    logic [7:0]        rdb_val;

    // output register
    logic              out_valid_reg;
    logic [7:0]        out_data_reg;
    logic              out_last_reg;
    logic [7:0]        out_byte;

    assign uc      = ucode_rom(pc_reg);
    assign step_en = !(uc.accept && !s_axis_tvalid)
                     && !(uc.emit && out_valid_reg && !m_axis_tready);

    assign s_axis_tready = uc.accept;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            key_len_reg  <= 5'd16;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_KEY_LOW:  key_low_reg  <= cfg_wdata;
                CFG_KEY_HIGH: key_high_reg <= cfg_wdata;
                CFG_KEY_LEN:  key_len_reg  <= cfg_wdata[4:0];
                default:      ;
            endcase
        end
    end

    // zero length acts as one, longer than supported saturates
    always_comb
    begin
        if (key_len_reg == 5'd0)
            key_len_eff = 5'd1;
        else if (key_len_reg > 5'(MAX_KEY_BYTES))
            key_len_eff = 5'(MAX_KEY_BYTES);
        else
            key_len_eff = key_len_reg;
    end

    always_comb
    begin
        logic [3:0]   sel;
        logic [127:0] key_all;
        sel     = 4'(kidx_reg);
        key_all = {key_high_reg, key_low_reg};
        key_sel = key_all[{sel, 3'b000} +: 8];
    end

    // ---------------- table memory ----------------
    // entries without a valid bit read as their own address (identity)
    assign rda_val = rda_hit_reg ? rda_data_reg : rda_addr_reg;
    assign rdb_val = rdb_hit_reg ? rdb_data_reg : rdb_addr_reg;

    always_comb
    begin
        case (uc.ra_sel)
            RA_X:       ra_addr = x_reg;
            RA_X_INC:   ra_addr = x_reg + 8'd1;
            RA_Y_SUM:   ra_addr = y_reg + rda_val;
            RA_KEY_SUM: ra_addr = y_reg + rda_val + key_sel;
            RA_AB:      ra_addr = a_reg + b_reg;
            default:    ra_addr = x_reg;
        endcase
    end

    assign rb_addr = b_reg;
    assign mem_we  = step_en && (uc.wr_sel != WR_NONE);
    assign mem_wa  = (uc.wr_sel == WR_X) ? x_reg : y_reg;
    assign mem_wd  = (uc.wr_sel == WR_X) ? rda_val : a_reg;

    // write-first: a read of the address being written returns the new byte
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (step_en && uc.rd_a)
        begin
            rda_addr_reg <= ra_addr;
            if (mem_we && mem_wa == ra_addr)
            begin
                rda_data_reg <= mem_wd;
                rda_hit_reg  <= 1'b1;
            end
            else
            begin
                rda_data_reg <= mem[ra_addr];
                rda_hit_reg  <= vld_reg[ra_addr];
            end
        end
        if (step_en && uc.rd_b)
        begin
            rdb_addr_reg <= rb_addr;
            if (mem_we && mem_wa == rb_addr)
            begin
                rdb_data_reg <= mem_wd;
                rdb_hit_reg  <= 1'b1;
            end
            else
            begin
                rdb_data_reg <= mem[rb_addr];
                rdb_hit_reg  <= vld_reg[rb_addr];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (step_en && uc.clr_tbl)
            vld_reg <= '0;
        else if (mem_we)
            vld_reg[mem_wa] <= 1'b1;
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        pc_next = pc_reg;
        if (step_en)
        begin
            case (uc.jmp)
                J_NEXT:     pc_next = pc_reg + 4'd1;
                J_DISPATCH: pc_next = (s_axis_tuser == MODE_REKEY) ? uc.target
                                                                   : pc_reg + 4'd1;
                J_GOTO:     pc_next = uc.target;
                J_LOOP:     pc_next = (x_reg == 8'hFF) ? pc_reg + 4'd1 : uc.target;
                default:    pc_next = STEP_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= STEP_IDLE;
            x_reg    <= '0;
            y_reg    <= '0;
            kidx_reg <= '0;
        end
        else
        begin
            pc_reg <= pc_next;
            if (step_en)
            begin
                case (uc.x_op)
                    X_INC:   x_reg <= x_reg + 8'd1;
                    X_CLR:   x_reg <= '0;
                    default: ;
                endcase
                case (uc.y_op)
                    Y_ADDR:  y_reg <= ra_addr;
                    Y_CLR:   y_reg <= '0;
                    default: ;
                endcase
                if (uc.clr_tbl)
                    kidx_reg <= '0;
                else if (uc.key_step)
                begin
                    if (5'(kidx_reg) + 5'd1 >= key_len_eff)
                        kidx_reg <= '0;
                    else
                        kidx_reg <= kidx_reg + KIDX_W'(1);
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            if (uc.accept)
            begin
                mode_reg <= s_axis_tuser;
                din_reg  <= s_axis_tdata;
                last_reg <= s_axis_tlast;
            end
            if (uc.ld_a)
                a_reg <= rda_val;
            if (uc.ld_b)
                b_reg <= rda_val;
        end
    end

    // ---------------- output ----------------
    // port A holds T[a+b] (keystream), port B holds T[b]
    always_comb
    begin
        case (mode_reg)
            MODE_ENC: out_byte = (din_reg ^ rda_val) + rdb_val;
            MODE_DEC: out_byte = (din_reg - rdb_val) ^ rda_val;
            default:  out_byte = din_reg ^ rda_val;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step_en && uc.emit)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step_en && uc.emit)
        begin
            out_data_reg <= out_byte;
            out_last_reg <= last_reg;
        end
    end

    // ---------------- assertions ----------------
    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg <= STEP_LAST)
        else $error("sequencer step out of program");

    a_rekey_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == MODE_REKEY)
        |=> pc_reg == STEP_KINIT)
        else $error("rekey transfer did not start key schedule");

    a_data_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser != MODE_REKEY)
        |=> pc_reg == STEP_G0)
        else $error("data transfer did not start generator step");

    a_no_clear_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(uc.clr_tbl && mem_we))
        else $error("table write during clear");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (uc.emit && step_en && out_valid_reg) |-> m_axis_tready)
        else $error("result overwritten before transfer");

endmodule

### tb/rc4kc_tb_pkg.sv
// ----------------------------------------------------------------------------
// rc4kc_tb_pkg: register map for the RC4 cipher testbench
// Register indexes of the configuration write port, shared by the stimulus
// and the checker.
// ----------------------------------------------------------------------------
package rc4kc_tb_pkg;

    typedef enum logic [1:0]
    {
        REG_KEY_LO  = 2'd0,   // key bytes 0..7
        REG_KEY_HI  = 2'd1,   // key bytes 8..15
        REG_KEY_LEN = 2'd2,   // bytes cycled by the key schedule
        REG_UNUSED  = 2'd3    // not mapped, writes are dropped
    } cfg_reg_t;

endpackage

### tb/rc4kc_checker.sv
// ----------------------------------------------------------------------------
// rc4kc_checker: scoreboard for the RC4 keystream cipher
// Tracks key register writes, predicts each output byte from the accepted
// input transfers and compares it with the output stream in order.
// ----------------------------------------------------------------------------
module rc4kc_checker
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_addr,
    input  logic [63:0]          cfg_wdata,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,
    input  rc4kc_pkg::mode_t     s_axis_tuser,
    input  logic                 s_axis_tlast,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [7:0]           m_axis_tdata,
    input  logic                 m_axis_tlast,
    output int                   fail_count,
    output int                   pending
);

    import rc4kc_pkg::*;
    import rc4kc_tb_pkg::*;

    localparam int PRINT_CAP = 100;

    typedef struct packed
    {
        logic [7:0] cipher_byte;
        logic       last;
    } cipher_result_t;

    logic [7:0]     sbox [256];
    logic [7:0]     idx_x;
    logic [7:0]     idx_y;
    logic [63:0]    key_lo;
    logic [63:0]    key_hi;
    logic [4:0]     key_len;
    cipher_result_t expected_bytes [$];

    task automatic report_fail(input string msg);
        if (fail_count < PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, msg);
        fail_count = fail_count + 1;
    endtask

    function automatic logic [7:0] key_byte(input int n);
        if (n < 8)
            return key_lo[8*n +: 8];
        return key_hi[8*(n-8) +: 8];
    endfunction

    task automatic fill_identity();
        for (int i = 0; i < 256; i++)
            sbox[i] = 8'(i);
        idx_x = 8'd0;
        idx_y = 8'd0;
    endtask

    task automatic run_key_schedule();
        logic [7:0] j;
        logic [7:0] t;
        int         kpos;
        int         klen;
        klen = key_len;
        if (klen < 1)
            klen = 1;
        if (klen > KEY_BYTES)
            klen = KEY_BYTES;
        fill_identity();
        j    = 8'd0;
        kpos = 0;
        for (int i = 0; i < 256; i++)
        begin
            t       = sbox[i];
            j       = j + t + key_byte(kpos);
            sbox[i] = sbox[j];
            sbox[j] = t;
            kpos++;
            if (kpos >= klen)
                kpos = 0;
        end
    endtask

    task automatic step_generator(input mode_t m, input logic [7:0] din, input logic lin);
        logic [7:0]     a;
        logic [7:0]     b;
        logic [7:0]     ks;
        logic [7:0]     d;
        cipher_result_t r;
        idx_x       = idx_x + 8'd1;
        a           = sbox[idx_x];
        idx_y       = idx_y + a;
        b           = sbox[idx_y];
        sbox[idx_x] = b;
        sbox[idx_y] = a;
        ks          = sbox[8'(a + b)];
        case (m)
            MODE_PLAIN: d = din ^ ks;
            MODE_ENC:   d = 8'((din ^ ks) + sbox[b]);
            default:    d = 8'(din - sbox[b]) ^ ks;
        endcase
        r.cipher_byte = d;
        r.last        = lin;
        expected_bytes.push_back(r);
    endtask

    task automatic check_output();
        cipher_result_t want;
        if (expected_bytes.size() == 0)
        begin
            report_fail($sformatf("unexpected output byte %02h last %0b",
                                  m_axis_tdata, m_axis_tlast));
            return;
        end
        want = expected_bytes.pop_front();
        if (m_axis_tdata !== want.cipher_byte)
            report_fail($sformatf("data_out %02h, expected %02h",
                                  m_axis_tdata, want.cipher_byte));
        if (m_axis_tlast !== want.last)
            report_fail($sformatf("last_out %0b, expected %0b (byte %02h)",
                                  m_axis_tlast, want.last, want.cipher_byte));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_identity();
            key_lo     = '0;
            key_hi     = '0;
            key_len    = 5'd16;
            fail_count = 0;
            expected_bytes.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_KEY_LO:  key_lo  = cfg_wdata;
                    REG_KEY_HI:  key_hi  = cfg_wdata;
                    REG_KEY_LEN: key_len = cfg_wdata[4:0];
                    default:     ;
                endcase
            end
            // output first: a same-edge input cannot own this result
            if (m_axis_tvalid && m_axis_tready)
                check_output();
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser == MODE_REKEY)
                    run_key_schedule();
                else
                    step_generator(s_axis_tuser, s_axis_tdata, s_axis_tlast);
            end
        end
        pending <= expected_bytes.size();
    end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for rc4_keystream_cipher_top
// Directed bytes at the edges of each mode and key setting, then random
// message traffic over four idle/stall profiles with fresh keys in between.
// The checker beside the block predicts and compares every output transfer.
// ----------------------------------------------------------------------------
module tb_top;

    import rc4kc_pkg::*;
    import rc4kc_tb_pkg::*;

    // run length guard
    localparam int CYCLE_LIMIT     = 1000000;
    // a rekey gives no output transfer, so
    // an empty scoreboard alone does not prove the block is idle
    localparam int REKEY_SETTLE    = 1100;
    // receiver hold-off long enough to back the block up into its input,
    // even when a rekey runs first
    localparam int LONG_HOLD       = 1500;
    localparam int ITEMS_PER_PHASE = 100;
    // leave margin after the drain for stray bytes
    localparam int DRAIN_TAIL      = 20;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_we        = 1'b0;
    logic [1:0]  cfg_addr      = 2'd0;
    logic [63:0] cfg_wdata     = 64'd0;
    logic        s_axis_tvalid = 1'b0;
    logic [7:0]  s_axis_tdata  = 8'd0;
    mode_t       s_axis_tuser  = MODE_PLAIN;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tready = 1'b0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    // traffic shaping, set per phase by the stimulus process
    int          idle_pct      = 0;
    int          stall_pct     = 0;
    logic        hold_req      = 1'b0;
    logic        hold_req_q    = 1'b0;
    int          hold_left     = 0;

    int          fail_count;
    int          pending;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    rc4_keystream_cipher_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    rc4kc_checker chk
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // Receiver: random stalls at stall_pct, or a long hold-off started by a
    // rising edge on hold_req. The hold is counted here so the sender keeps
    // pushing transfers while the output side stays blocked.
    always @(posedge clk)
    begin
        hold_req_q <= hold_req;
        if (hold_req && !hold_req_q)
        begin
            hold_left     <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Offer one item and hold it until the transfer. Idle cycles go in front
    // at idle_pct; tvalid gets a single assignment per clock edge.
    task automatic push_item(input mode_t m, input logic [7:0] d, input logic l);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= m;
        s_axis_tdata  <= d;
        s_axis_tlast  <= l;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Stop offering and wait until every predicted byte has come out.
    // It first lets the scoreboard count take in the last transfer.
    task automatic drain_outputs();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [63:0] v);
        cfg_we    <= 1'b1;
        cfg_addr  <= r;
        cfg_wdata <= v;
        @(posedge clk);
    endtask

    // Key registers only change with the block idle: drain, let any rekey
    // finish, then write all registers plus the unmapped index.
    task automatic load_key(input logic [63:0] lo, input logic [63:0] hi,
                            input logic [4:0] len);
        drain_outputs();
        repeat (REKEY_SETTLE) @(posedge clk);
        write_reg(REG_KEY_LO, lo);
        write_reg(REG_KEY_HI, hi);
        write_reg(REG_KEY_LEN, {59'd0, len});
        write_reg(REG_UNUSED, {$urandom, $urandom});
        cfg_we <= 1'b0;
    endtask

    // Random traffic: mostly messages of one mode closed by tlast, some
    // noisy bursts with random modes and tlast, and the odd rekey.
    task automatic run_traffic(input int n_items);
        int    sent;
        int    msg_len;
        bit    noisy;
        mode_t m;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(99) < 6)
            begin
                push_item(MODE_REKEY, 8'($urandom), 1'($urandom));
                sent++;
            end
            msg_len = $urandom_range(12, 1);
            noisy   = ($urandom_range(99) < 15);
            m       = mode_t'($urandom_range(3, 1));
            for (int i = 0; i < msg_len; i++)
            begin
                if (noisy)
                    push_item(mode_t'($urandom_range(3)), 8'($urandom_range(255)),
                              1'($urandom_range(1)));
                else
                    push_item(m, 8'($urandom_range(255)), i == msg_len - 1);
            end
            sent += msg_len;
        end
    endtask

    // watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        logic [4:0] len;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed: generator straight out of reset (identity table)
        push_item(MODE_PLAIN, 8'h00, 1'b0);
        push_item(MODE_PLAIN, 8'hFF, 1'b1);
        push_item(MODE_ENC,   8'h00, 1'b0);
        push_item(MODE_ENC,   8'hFF, 1'b1);
        push_item(MODE_DEC,   8'h00, 1'b0);
        push_item(MODE_DEC,   8'hFF, 1'b0);
        push_item(MODE_DEC,   8'hA5, 1'b1);
        // rekey with the reset key (all zero, length 16); tlast is don't-care
        push_item(MODE_REKEY, 8'h77, 1'b1);
        push_item(MODE_PLAIN, 8'h5A, 1'b0);
        push_item(MODE_ENC,   8'hC3, 1'b0);
        push_item(MODE_DEC,   8'h3C, 1'b1);

        // zero key length behaves as length one
        load_key(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 5'd0);
        push_item(MODE_REKEY, 8'h00, 1'b0);
        push_item(MODE_PLAIN, 8'h55, 1'b0);
        push_item(MODE_PLAIN, 8'hAA, 1'b0);
        push_item(MODE_DEC,   8'h81, 1'b1);

        // largest length saturates at 16; all-ones key
        load_key('1, '1, 5'd31);
        push_item(MODE_REKEY, 8'hFF, 1'b1);
        push_item(MODE_ENC,   8'hFF, 1'b1);
        push_item(MODE_PLAIN, 8'h00, 1'b0);

        // single-byte key
        load_key(64'h0000_0000_0000_00A7, 64'd0, 5'd1);
        push_item(MODE_REKEY, 8'h00, 1'b0);
        push_item(MODE_DEC,   8'h80, 1'b1);

        // --- random phases: none, sender idle, receiver stall, both
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:       len = 5'd16;
                1:       len = 5'd1;
                2:       len = 5'($urandom_range(15, 2));
                default: len = 5'($urandom_range(31));
            endcase
            load_key({$urandom, $urandom}, {$urandom, $urandom}, len);
            idle_pct  = (p == 1) ? 50 : (p == 3) ? 32 : 0;
            stall_pct = (p == 2) ? 50 : (p == 3) ? 32 : 0;
            push_item(MODE_REKEY, 8'($urandom), 1'($urandom));
            if (p == 0)
            begin
                // let the rekey finish, then hold the receiver off while
                // traffic keeps coming
                drain_outputs();
                repeat (REKEY_SETTLE) @(posedge clk);
                hold_req <= 1'b1;
                @(posedge clk);
                hold_req <= 1'b0;
            end
            run_traffic(ITEMS_PER_PHASE);
        end

        drain_outputs();
        repeat (DRAIN_TAIL) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### files.f
sv/rc4kc_pkg.sv
sv/rc4_keystream_cipher_top.sv
tb/rc4kc_tb_pkg.sv
tb/rc4kc_checker.sv
tb/tb_top.sv
